// ----- hw/rtl/hdlm_pkg.sv -----
// Package for the half-duplex link master: payload types, phase and kind codes.
// No dependencies.
package hdlm_pkg;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] byte_value;
      logic [8:0] request_length;
      logic [7:0] request_command;
      logic       line_empty;
   } req_type;

   typedef struct packed {
      logic       drive_valid;
      logic [7:0] drive_byte;
      logic       drive_enable;
      logic       got_valid;
      logic [7:0] got_byte;
      logic [7:0] got_index;
      logic       link_up;
      logic [7:0] peer_command;
      logic       send_ready;
      logic [2:0] phase;
      logic       last;
   } rsp_type;

   localparam logic [2:0] KIND_TICK = 3'd0;
   localparam logic [2:0] KIND_LINE = 3'd1;
   localparam logic [2:0] KIND_SEND = 3'd2;
   localparam logic [2:0] KIND_RECV = 3'd3;
   localparam logic [2:0] KIND_LOAD = 3'd4;

   localparam logic [2:0] PH_IDLE   = 3'd0;
   localparam logic [2:0] PH_WAIT   = 3'd1;
   localparam logic [2:0] PH_TXCMD  = 3'd2;
   localparam logic [2:0] PH_RXCMD  = 3'd3;
   localparam logic [2:0] PH_TXDATA = 3'd4;
   localparam logic [2:0] PH_RXDATA = 3'd5;

   localparam logic [7:0] HELLO_BYTE = 8'h55;

endpackage

// ----- hw/rtl/hdlm_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module hdlm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

// ----- hw/rtl/hdlm_queue.sv -----
// Short request queue between the front end and the link engine.
// Depends on hdlm_pkg.
module hdlm_queue #(
   parameter int DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  hdlm_pkg::req_type push_data,
   output logic              full,
   input  logic              pop,
   output hdlm_pkg::req_type pop_data,
   output logic              empty
);
   import hdlm_pkg::*;
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   req_type        slot_ff [DEPTH];
   logic [AW-1:0]  wp_ff, wp_in, rp_ff, rp_in;
   logic [AW:0]    cnt_ff, cnt_in;
   logic           do_push, do_pop;

   assign full     = (cnt_ff == (AW+1)'(DEPTH));
   assign empty    = (cnt_ff == '0);
   assign pop_data = slot_ff[rp_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   // pointer and count update
   always_comb begin
      wp_in  = wp_ff;
      rp_in  = rp_ff;
      cnt_in = cnt_ff;
      if (do_push) wp_in = (wp_ff == AW'(DEPTH-1)) ? '0 : wp_ff + 1'b1;
      if (do_pop)  rp_in = (rp_ff == AW'(DEPTH-1)) ? '0 : rp_ff + 1'b1;
      if (do_push && !do_pop) cnt_in = cnt_ff + 1'b1;
      if (do_pop && !do_push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) slot_ff[wp_ff] <= push_data;
   end
endmodule

// ----- hw/rtl/hdlm_engine.sv -----
// Link engine: executes one queued request, drives bytes out of the payload store.
// Depends on hdlm_pkg and hdlm_ram.
module hdlm_engine #(
   parameter int MAX_PAYLOAD = 256,
   parameter int BURST_BYTES = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  hdlm_pkg::req_type req_data,
   output logic              req_take,
   output logic              out_valid,
   output hdlm_pkg::rsp_type out_data,
   input  logic              out_take
);
   import hdlm_pkg::*;
   localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
   localparam int LW = $clog2(MAX_PAYLOAD + 1);
   localparam int BW = $clog2(BURST_BYTES + 1);

   // sequencer codes
   localparam logic [1:0] SQ_IDLE  = 2'd0;
   localparam logic [1:0] SQ_READ  = 2'd1;
   localparam logic [1:0] SQ_BURST = 2'd2;
   localparam logic [1:0] SQ_EMIT  = 2'd3;

   logic [1:0]    sq_ff, sq_in;
   logic [2:0]    phase_ff, phase_in;
   logic [7:0]    own_ff, own_in, peer_ff, peer_in;
   logic [LW-1:0] txl_ff, txl_in, rxl_ff, rxl_in, rxt_ff, rxt_in;
   logic [LW-1:0] txt_ff, txt_in, echo_ff, echo_in;
   logic          conn_ff, conn_in;
   logic [AW-1:0] lp_ff, lp_in;
   logic [BW-1:0] bl_ff, bl_in;
   rsp_type       r_ff, r_in;
   logic          rv_ff, rv_in;

   logic          wr_en;
   logic [AW-1:0] rd_addr;
   logic [7:0]    rd_data;
   logic [LW-1:0] len;
   logic [LW:0]   lenx;
   logic          go_burst, go_cmd;
   logic [LW-1:0] sent;

   hdlm_ram #(.WIDTH(8), .DEPTH(MAX_PAYLOAD)) u_store (
      .clock(clock), .wr_en(wr_en), .wr_addr(lp_ff), .wr_data(req_data.byte_value),
      .rd_addr(rd_addr), .rd_data(rd_data));

   assign req_take  = req_valid && (sq_ff == SQ_IDLE) && !rv_ff;
   assign wr_en     = req_take && (req_data.kind == KIND_LOAD);
   assign out_valid = rv_ff;
   assign out_data  = r_ff;
   assign lenx      = (LW+1)'(req_data.request_length);
   assign len       = (lenx > (LW+1)'(MAX_PAYLOAD)) ? LW'(MAX_PAYLOAD) : LW'(lenx);
   assign sent      = txt_ff - txl_ff;
   // sent stays below MAX_PAYLOAD while a burst byte is read
   assign rd_addr   = AW'(sent);

   // request execution and burst sequencing
   always_comb begin
      logic [7:0]    b;
      logic          clr, idle_go;
      sq_in = sq_ff; phase_in = phase_ff; own_in = own_ff; peer_in = peer_ff;
      txl_in = txl_ff; rxl_in = rxl_ff; rxt_in = rxt_ff; txt_in = txt_ff;
      echo_in = echo_ff; conn_in = conn_ff; lp_in = lp_ff; bl_in = bl_ff;
      r_in = r_ff; rv_in = rv_ff;
      go_burst = 1'b0; go_cmd = 1'b0; clr = 1'b0; idle_go = 1'b0;
      b = req_data.byte_value;
      r_in.got_valid = 1'b0; r_in.got_byte = '0; r_in.got_index = '0;

      if (rv_ff && out_take) rv_in = 1'b0;

      case (sq_ff)
         SQ_IDLE: if (req_take) begin
            case (req_data.kind)
               KIND_TICK: begin
                  if (phase_ff == PH_IDLE) go_cmd = 1'b1;
                  else if ((phase_ff == PH_RXCMD || phase_ff == PH_RXDATA) &&
                           req_data.line_empty) begin
                     conn_in = 1'b0; clr = 1'b1; go_cmd = 1'b1;
                  end
               end
               KIND_LINE: begin
                  case (phase_ff)
                     PH_TXCMD: begin
                        if (echo_ff != '0) echo_in = echo_ff - 1'b1;
                        if (peer_ff == '0) phase_in = PH_RXCMD;
                        else if (rxl_ff != '0) phase_in = PH_RXDATA;
                     end
                     PH_RXCMD: begin
                        peer_in = b;
                        if (b == HELLO_BYTE) begin
                           if (txl_ff != '0) go_burst = 1'b1; else idle_go = 1'b1;
                        end else if (rxl_ff == '0) phase_in = PH_WAIT;
                        else if (txl_ff != '0) go_burst = 1'b1;
                        else go_cmd = 1'b1;
                     end
                     PH_TXDATA: begin
                        if (echo_ff != '0) echo_in = echo_ff - 1'b1;
                        if (txl_ff != '0 && echo_in == txl_ff) begin
                           sq_in = SQ_READ;
                           bl_in = (txl_ff < LW'(BURST_BYTES)) ? BW'(txl_ff)
                                                                : BW'(BURST_BYTES);
                        end else if (echo_in == '0) begin
                           if (rxl_ff != '0) phase_in = PH_RXDATA; else idle_go = 1'b1;
                        end
                     end
                     PH_RXDATA: begin
                        if (rxl_ff == '0) idle_go = 1'b1;
                        else begin
                           r_in.got_valid = 1'b1;
                           r_in.got_byte  = b;
                           r_in.got_index = 8'(rxt_ff - rxl_ff);
                           rxl_in = rxl_ff - 1'b1;
                           if (rxl_ff == LW'(1)) idle_go = 1'b1;
                        end
                     end
                     default: ;
                  endcase
               end
               KIND_SEND: begin
                  own_in = req_data.request_command;
                  txl_in = len; txt_in = len; lp_in = '0;
               end
               KIND_RECV: begin
                  rxl_in = len; rxt_in = len;
                  if (phase_ff == PH_WAIT) begin
                     if (txl_ff != '0) go_burst = 1'b1;
                     else if (len != '0) go_cmd = 1'b1;
                     else idle_go = 1'b1;
                  end
               end
               KIND_LOAD: lp_in = (lp_ff == AW'(MAX_PAYLOAD-1)) ? '0 : lp_ff + 1'b1;
               default: ;
            endcase

            if (idle_go) begin
               phase_in = PH_IDLE;
               if (peer_in != '0) conn_in = 1'b1;
               clr = 1'b1;
            end
            if (clr) begin
               own_in = '0; txl_in = '0; txt_in = '0; peer_in = '0;
               rxl_in = '0; rxt_in = '0; echo_in = '0;
            end
            if (go_cmd) begin
               phase_in = PH_TXCMD; echo_in = LW'(1);
               r_in.drive_valid = 1'b1;
               r_in.drive_byte  = (own_in != '0) ? own_in : HELLO_BYTE;
            end else begin
               r_in.drive_valid = 1'b0; r_in.drive_byte = '0;
            end
            if (go_burst) begin
               phase_in = PH_TXDATA; echo_in = txl_ff; sq_in = SQ_READ;
               bl_in = (txl_ff < LW'(BURST_BYTES)) ? BW'(txl_ff) : BW'(BURST_BYTES);
            end
            if (sq_in == SQ_IDLE) begin
               r_in.last = 1'b1; rv_in = 1'b1;
            end
         end
         SQ_READ: sq_in = SQ_BURST;
         // one byte per pass: RAM read data valid here
         SQ_BURST: begin
            r_in.drive_valid = 1'b1;
            r_in.drive_byte  = rd_data;
            r_in.last        = (bl_ff == BW'(1));
            txl_in = txl_ff - 1'b1;
            bl_in  = bl_ff - 1'b1;
            rv_in  = 1'b1;
            sq_in  = SQ_EMIT;
         end
         SQ_EMIT: if (rv_ff && out_take) begin
            r_in.got_valid = 1'b0;
            sq_in = (bl_ff == '0) ? SQ_IDLE : SQ_BURST;
            if (bl_ff != '0) sq_in = SQ_READ;
         end
         default: sq_in = SQ_IDLE;
      endcase

      // status fields reflect state after the request
      r_in.drive_enable = (phase_in == PH_TXCMD || phase_in == PH_TXDATA);
      r_in.link_up      = conn_in;
      r_in.peer_command = (phase_in == PH_WAIT) ? peer_in : '0;
      r_in.send_ready   = (phase_in == PH_IDLE && own_in == '0);
      r_in.phase        = phase_in;
      // a waiting result stays put until a new request or burst byte replaces it
      if (sq_ff == SQ_READ || sq_ff == SQ_EMIT || (sq_ff == SQ_IDLE && !req_take))
         r_in = r_ff;
      if (sq_ff == SQ_EMIT && rv_ff && out_take) r_in.got_valid = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_ff <= SQ_IDLE; phase_ff <= PH_IDLE; own_ff <= '0; peer_ff <= '0;
         txl_ff <= '0; rxl_ff <= '0; rxt_ff <= '0; txt_ff <= '0; echo_ff <= '0;
         conn_ff <= 1'b0; lp_ff <= '0; bl_ff <= '0; rv_ff <= 1'b0;
      end else begin
         sq_ff <= sq_in; phase_ff <= phase_in; own_ff <= own_in; peer_ff <= peer_in;
         txl_ff <= txl_in; rxl_ff <= rxl_in; rxt_ff <= rxt_in; txt_ff <= txt_in;
         echo_ff <= echo_in; conn_ff <= conn_in; lp_ff <= lp_in; bl_ff <= bl_in;
         rv_ff <= rv_in;
      end
      r_ff <= r_in;
   end
endmodule

// ----- hw/rtl/half_duplex_link_master_top.sv -----
// Half-duplex link master, top level.
// Each request passes through the request queue and then the engine's result register.
// The engine takes a new request only when idle with no result waiting; burst bytes
// pass one at a time through the payload RAM read and one result register.
// Reset: synchronous active-high reset idles the link; payload RAM is not cleared.
module half_duplex_link_master_top #(
   parameter int MAX_PAYLOAD = 256,
   parameter int BURST_BYTES = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  hdlm_pkg::req_type req_data,
   output logic              full,
   output logic              empty,
   input  logic              pop,
   output hdlm_pkg::rsp_type rsp_data
);
   import hdlm_pkg::*;

   req_type q_data;
   logic    q_empty, q_take, out_valid;

   // front end: request queue
   hdlm_queue #(.DEPTH(2)) u_queue (
      .clock(clock), .reset(reset), .push(push), .push_data(req_data), .full(full),
      .pop(q_take), .pop_data(q_data), .empty(q_empty));

   // back end: link engine
   hdlm_engine #(.MAX_PAYLOAD(MAX_PAYLOAD), .BURST_BYTES(BURST_BYTES)) u_engine (
      .clock(clock), .reset(reset), .req_valid(!q_empty), .req_data(q_data),
      .req_take(q_take), .out_valid(out_valid), .out_data(rsp_data), .out_take(pop));

   assign empty = !out_valid;
endmodule
